>>> sv/quadword_fifo_bit_reader_macros.svh
// ============================================================================
// quadword_fifo_bit_reader_macros: assertion macros for the bit reader.
// The macros expect signals named clk and rst in the scope of their use.
// ============================================================================
`ifndef QUADWORD_FIFO_BIT_READER_MACROS_SVH
`define QUADWORD_FIFO_BIT_READER_MACROS_SVH

// Property checked at every rising edge outside reset.
`define QFBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define QFBR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/qfbr_pkg.sv
// ============================================================================
// qfbr_pkg: shared types and constants of the quadword FIFO bit reader.
// Holds opcodes, field widths, control structs and the byte reordering.
// ============================================================================
package qfbr_pkg;

  localparam int QW_BITS  = 128;
  localparam int WORD_W   = 64;
  localparam int DATA_W   = 32;
  localparam int MAX_BITS = 32;
  localparam int OP_W     = 3;
  localparam int CNT_W    = 6;
  localparam int OFS_W    = 7;
  localparam int BUF_W    = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_PEEK    = 3'd1,
    OP_ADVANCE = 3'd2,
    OP_ALIGN   = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  typedef struct packed {
    logic             success;
    logic             peek_en;
    logic [BUF_W-1:0] bits_buffered;
  } ctrl_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0] peek_data;
    logic              success;
    logic [BUF_W-1:0]  bits_buffered;
  } result_t;

  // Places stream byte k at the top end so that stream bit p sits at bit 127-p.
  function automatic logic [QW_BITS-1:0] stream_order(input logic [WORD_W-1:0] lo,
                                                      input logic [WORD_W-1:0] hi);
    logic [2*WORD_W-1:0] raw;
    logic [QW_BITS-1:0]  res;
    raw = {hi, lo};
    for (int k = 0; k < QW_BITS / 8; k++) begin
      res[QW_BITS-1-8*k -: 8] = raw[8*k +: 8];
    end
    return res;
  endfunction

endpackage

>>> sv/qfbr_if.sv
// ============================================================================
// qfbr_if: command and response channels of the quadword FIFO bit reader.
// Each channel moves one beat when valid and ready are both high.
// ============================================================================
interface qfbr_cmd_if;
  import qfbr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CNT_W-1:0]  bit_count;
  logic [WORD_W-1:0] word_low;
  logic [WORD_W-1:0] word_high;

  modport source (output valid, output opcode, output bit_count, output word_low,
                  output word_high, input ready);
  modport sink (input valid, input opcode, input bit_count, input word_low,
                input word_high, output ready);
endinterface

interface qfbr_rsp_if;
  import qfbr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] peek_data;
  logic              success;
  logic [BUF_W-1:0]  bits_buffered;

  modport source (output valid, output peek_data, output success, output bits_buffered,
                  input ready);
  modport sink (input valid, input peek_data, input success, input bits_buffered,
                output ready);
endinterface

>>> sv/qfbr_cell.sv
// ============================================================================
// qfbr_cell: one quadword slot of the FIFO chain.
// Loads a pushed quadword at its own index and takes its neighbor on a pop.
// ============================================================================
module qfbr_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 4
) (
  input  logic                          clk,
  input  qfbr_pkg::cell_ctl_t           ctl,
  input  logic [CW-1:0]                 fill,
  input  logic [qfbr_pkg::QW_BITS-1:0]  load_data,
  input  logic [qfbr_pkg::QW_BITS-1:0]  from_next,
  output logic [qfbr_pkg::QW_BITS-1:0]  data
);
  import qfbr_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.push && fill == CW'(INDEX)) begin
      data <= load_data;
    end else if (ctl.pop) begin
      data <= from_next;
    end
  end

endmodule

>>> sv/qfbr_window.sv
// ============================================================================
// qfbr_window: bit extractor for peeks.
// Selects up to 32 bits at the read offset from the head quadword and the top
// of the following one, right-aligned.
// ============================================================================
module qfbr_window (
  input  logic [qfbr_pkg::QW_BITS-1:0] head,
  input  logic [qfbr_pkg::DATA_W-1:0]  follow,
  input  logic [qfbr_pkg::OFS_W-1:0]   offset,
  input  logic [qfbr_pkg::CNT_W-1:0]   bits,
  output logic [qfbr_pkg::DATA_W-1:0]  data
);
  import qfbr_pkg::*;

  logic [QW_BITS+DATA_W-1:0] span;
  logic [DATA_W-1:0]         lead;
  logic [CNT_W-1:0]          drop;

  assign span = {head, follow} << offset;
  assign lead = span[QW_BITS+DATA_W-1 -: DATA_W];
  assign drop = CNT_W'(DATA_W) - bits;
  assign data = lead >> drop;

endmodule

>>> sv/qfbr_ctrl.sv
// ============================================================================
// qfbr_ctrl: fill count and read offset of the bit reader.
// Decodes each accepted beat, checks a push against the fill count and a peek
// or advance against the buffered bits and drives push and pop to the cells.
// ============================================================================
module qfbr_ctrl #(
  parameter int FIFO_DEPTH = 8,
  parameter int CW         = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [qfbr_pkg::OP_W-1:0]     opcode,
  input  logic [qfbr_pkg::CNT_W-1:0]    bit_count,
  output qfbr_pkg::cell_ctl_t           ctl,
  output logic [CW-1:0]                 count,
  output logic [qfbr_pkg::OFS_W-1:0]    offset,
  output qfbr_pkg::ctrl_stat_t          stat
);
  import qfbr_pkg::*;

  localparam int BW = (CW + OFS_W > BUF_W) ? CW + OFS_W : BUF_W;

  logic [CW-1:0]    count_next;
  logic [OFS_W-1:0] offset_next;
  logic [BW-1:0]    cap;
  logic [BW-1:0]    avail;
  logic [BW-1:0]    left_next;
  logic [CNT_W-1:0] adv_amount;
  logic [CNT_W-1:0] align_amount;
  logic [CNT_W-1:0] amount;
  logic [OFS_W:0]   sum;
  logic             adv_ok;
  logic             peek_ok;
  logic             push_ok;

  assign cap          = BW'({count, {OFS_W{1'b0}}});
  assign avail        = cap - BW'(offset);
  assign adv_amount   = (bit_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : bit_count;
  assign align_amount = (offset[2:0] == 3'd0) ? '0 : CNT_W'(4'd8 - {1'b0, offset[2:0]});
  assign amount       = (opcode == OP_ALIGN) ? align_amount : adv_amount;
  assign sum          = {1'b0, offset} + (OFS_W+1)'(amount);
  assign adv_ok       = BW'(sum) <= cap;
  assign peek_ok      = (bit_count <= CNT_W'(MAX_BITS)) && (avail != '0)
                        && (BW'(bit_count) <= avail);
  assign push_ok      = count < CW'(FIFO_DEPTH);
  assign left_next    = BW'({count_next, {OFS_W{1'b0}}}) - BW'(offset_next);

  always_comb begin
    count_next   = count;
    offset_next  = offset;
    ctl          = '0;
    stat.success = 1'b0;
    stat.peek_en = 1'b0;
    if (accept) begin
      unique case (opcode)
        OP_PUSH: begin
          if (push_ok) begin
            ctl.push     = 1'b1;
            count_next   = count + CW'(1);
            stat.success = 1'b1;
          end
        end
        OP_PEEK: begin
          if (peek_ok) begin
            stat.success = 1'b1;
            stat.peek_en = 1'b1;
          end
        end
        OP_ADVANCE, OP_ALIGN: begin
          if (adv_ok) begin
            stat.success = 1'b1;
            offset_next  = sum[OFS_W-1:0];
            if (sum[OFS_W]) begin
              ctl.pop    = 1'b1;
              count_next = count - CW'(1);
            end
          end
        end
        OP_CLEAR: begin
          count_next   = '0;
          offset_next  = '0;
          stat.success = 1'b1;
        end
        default: begin
        end
      endcase
    end
    stat.bits_buffered = left_next[BUF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      offset <= '0;
    end else begin
      count  <= count_next;
      offset <= offset_next;
    end
  end

endmodule

>>> sv/quadword_fifo_bit_reader.sv
// ============================================================================
// quadword_fifo_bit_reader: big-endian bit reader over a chain of quadword cells.
// A response beat is registered from its command beat, or held in a skid register while
// the output stalls; one beat per cycle until a stalled response fills the skid register.
// Reset clears fill count, read offset and held response beats, not cell data.
// ============================================================================
module quadword_fifo_bit_reader #(
  parameter int FIFO_DEPTH = 8
) (
  input logic        clk,
  input logic        rst,
  qfbr_cmd_if.sink   cmd,
  qfbr_rsp_if.source rsp
);
  import qfbr_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic               accept;
  cell_ctl_t          cell_ctl;
  ctrl_stat_t         stat;
  logic [CW-1:0]      count;
  logic [OFS_W-1:0]   offset;
  logic [QW_BITS-1:0] load_data;
  logic [QW_BITS-1:0] cell_data [FIFO_DEPTH];
  logic [QW_BITS-1:0] next_data [FIFO_DEPTH];
  logic [DATA_W-1:0]  win_data;
  result_t            res;
  result_t            out_beat;
  result_t            skid_beat;
  logic               out_valid;
  logic               skid_valid;

  assign cmd.ready = !skid_valid;
  assign accept    = cmd.valid && cmd.ready;
  assign load_data = stream_order(cmd.word_low, cmd.word_high);

  qfbr_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .opcode    (cmd.opcode),
    .bit_count (cmd.bit_count),
    .ctl       (cell_ctl),
    .count     (count),
    .offset    (offset),
    .stat      (stat)
  );

  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    if (i < FIFO_DEPTH - 1) begin : g_mid
      assign next_data[i] = cell_data[i+1];
    end else begin : g_last
      assign next_data[i] = '0;
    end

    qfbr_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .fill      (count),
      .load_data (load_data),
      .from_next (next_data[i]),
      .data      (cell_data[i])
    );
  end

  qfbr_window u_window (
    .head   (cell_data[0]),
    .follow (cell_data[1][QW_BITS-1 -: DATA_W]),
    .offset (offset),
    .bits   (cmd.bit_count),
    .data   (win_data)
  );

  assign res.peek_data     = stat.peek_en ? win_data : '0;
  assign res.success       = stat.success;
  assign res.bits_buffered = stat.bits_buffered;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      out_beat <= skid_valid ? skid_beat : res;
    end else if (accept) begin
      skid_beat <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.peek_data     = out_beat.peek_data;
  assign rsp.success       = out_beat.success;
  assign rsp.bits_buffered = out_beat.bits_buffered;

endmodule

>>> sv/qfbr_checker.sv
// ============================================================================
// qfbr_checker: port-level checks of the quadword FIFO bit reader.
// Watches the command and response channels and is bound to the top level.
// ============================================================================
`include "quadword_fifo_bit_reader_macros.svh"

module qfbr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [qfbr_pkg::DATA_W-1:0]  peek_data,
  input logic                         success,
  input logic [qfbr_pkg::BUF_W-1:0]   bits_buffered
);
  import qfbr_pkg::*;

  `QFBR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(peek_data) && $stable(success) && $stable(bits_buffered), "stalled response beat changed")
  `QFBR_ASSERT(a_stall_needs_beat, !cmd_ready |-> rsp_valid, "command stalled with no response beat waiting")
  `QFBR_ASSERT(a_beat_follows, cmd_valid && cmd_ready && !rsp_valid |=> rsp_valid, "accepted command gave no response beat")
  `QFBR_ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp_valid && cmd_ready, "reset left a response beat or a stall")

endmodule

bind quadword_fifo_bit_reader qfbr_checker u_qfbr_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .peek_data     (rsp.peek_data),
  .success       (rsp.success),
  .bits_buffered (rsp.bits_buffered)
);
